FILE: rtl/core/point_perspective_projector_assert.svh
// Assertion macros shared by the projector RTL.
// Depends on a clock named clock and a reset named reset in the including scope.
`ifndef POINT_PERSPECTIVE_PROJECTOR_ASSERT_SVH
`define POINT_PERSPECTIVE_PROJECTOR_ASSERT_SVH

// Same-cycle implication, off during reset.
`define PPP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("projector assertion failed");

// Next-cycle implication, off during reset.
`define PPP_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("projector assertion failed");

`endif

FILE: rtl/core/ppp_pkg.sv
// Shared types, widths, register indexes and trig functions of the projector.
// No dependencies.
`timescale 1ns / 1ps
package ppp_pkg;

   localparam int unsigned XY_W    = 30;  // world x, y in Q.8
   localparam int unsigned Z_W     = 33;  // world z in Q.8
   localparam int unsigned ROT_W   = 35;  // rotated values
   localparam int unsigned TRIG_W  = 16;  // Q1.15
   localparam int unsigned PROD_W  = TRIG_W + ROT_W;
   localparam int unsigned SUM_W   = PROD_W + 1;
   localparam int unsigned NUM_W   = 46;  // magnitude of the numerator
   localparam int unsigned DEN_W   = 34;  // magnitude of the depth
   localparam int unsigned SCR_W   = 48;  // screen value before clamping
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 21;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned DEF_SCREEN_WIDTH  = 1024;
   localparam int unsigned DEF_SCREEN_HEIGHT = 768;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CAMERA_X   = 3'd0,
      REG_CAMERA_Y   = 3'd1,
      REG_CAMERA_Z   = 3'd2,
      REG_ANGLE_X    = 3'd3,
      REG_ANGLE_Y    = 3'd4,
      REG_ANGLE_Z    = 3'd5,
      REG_DEPTH_GAIN = 3'd6
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_ZERO_DEPTH = 2'd1,
      ST_SATURATED = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] sin_x;
      logic signed [TRIG_W-1:0] cos_x;
      logic signed [TRIG_W-1:0] sin_y;
      logic signed [TRIG_W-1:0] cos_y;
      logic signed [TRIG_W-1:0] sin_z;
      logic signed [TRIG_W-1:0] cos_z;
   } trig_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } vertex_type;

   localparam logic [15:0] SIN_QUARTER [0:90] = '{
      16'd0, 16'd572, 16'd1144, 16'd1715, 16'd2286, 16'd2856, 16'd3425, 16'd3993,
      16'd4560, 16'd5126, 16'd5690, 16'd6252, 16'd6813, 16'd7371, 16'd7927, 16'd8481,
      16'd9032, 16'd9580, 16'd10126, 16'd10668, 16'd11207, 16'd11743, 16'd12275,
      16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
      16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324, 16'd18795, 16'd19261,
      16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498, 16'd21926, 16'd22348,
      16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730, 16'd25102,
      16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842, 16'd27166, 16'd27482,
      16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
      16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592, 16'd30792, 16'd30983,
      16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795, 16'd31928, 16'd32052,
      16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588, 16'd32643,
      16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32767
   };

   // Sine of a whole-degree angle below 720, in Q1.15.
   function automatic logic signed [TRIG_W-1:0] sin_q15(input logic [9:0] d_in);
      logic [9:0] d;
      logic [9:0] idx;
      logic       neg;
      logic [15:0] m;
      d   = (d_in >= 10'd360) ? d_in - 10'd360 : d_in;
      neg = 1'b0;
      if (d <= 10'd90) begin
         idx = d;
      end else if (d <= 10'd180) begin
         idx = 10'd180 - d;
      end else if (d <= 10'd270) begin
         idx = d - 10'd180;
         neg = 1'b1;
      end else begin
         idx = 10'd360 - d;
         neg = 1'b1;
      end
      m = SIN_QUARTER[idx[6:0]];
      return neg ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [TRIG_W-1:0] cos_q15(input logic [8:0] ang);
      logic [9:0] d;
      d = {1'b0, ang};
      if (d >= 10'd360) begin
         d = d - 10'd360;
      end
      return sin_q15(d + 10'd90);
   endfunction

   // Rounds a Q1.15 product sum back to Q.8, halves away from zero.
   function automatic logic signed [ROT_W-1:0] round15(input logic signed [SUM_W-1:0] p);
      logic [SUM_W-1:0] mag;
      logic [SUM_W-1:0] r;
      mag = p[SUM_W-1] ? SUM_W'(-p) : SUM_W'(p);
      r   = (mag + SUM_W'(16384)) >> 15;
      return p[SUM_W-1] ? -$signed(r[ROT_W-1:0]) : $signed(r[ROT_W-1:0]);
   endfunction

endpackage

FILE: rtl/core/ppp_if.sv
// Channel interfaces of the projector: vertex input, screen result, register writes.
// Depends on ppp_pkg.
`timescale 1ns / 1ps
interface ppp_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] grid_col;
   logic [11:0] grid_row;
   logic signed [15:0] height;
   modport source (output valid, grid_col, grid_row, height, input ready);
   modport sink   (input valid, grid_col, grid_row, height, output ready);
endinterface

interface ppp_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] screen_x;
   logic signed [31:0] screen_y;
   logic [1:0]  status;
   modport source (output valid, screen_x, screen_y, status, input ready);
   modport sink   (input valid, screen_x, screen_y, status, output ready);
endinterface

interface ppp_csr_if;
   logic valid;
   logic ready;
   logic [ppp_pkg::CSR_IDX_W-1:0]  index;
   logic [ppp_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/ppp_front.sv
// Front end: configuration registers, trig lookup and world placement of each vertex.
// Depends on ppp_pkg and ppp_if.
`timescale 1ns / 1ps
module ppp_front (
   input  logic clock,
   input  logic reset,
   ppp_csr_if.sink csr_ch,
   ppp_req_if.sink req_ch,
   input  logic full_i,
   output logic push_o,
   output ppp_pkg::vertex_type vtx_o,
   output ppp_pkg::trig_type trig_o
);

   logic signed [20:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic [8:0]  ang_x_ff, ang_y_ff, ang_z_ff;
   logic [15:0] gain_ff;
   ppp_pkg::trig_type trig_ff, trig_in;

   logic signed [21:0] col30, row30, dx, dy;
   logic signed [33:0] hz;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff <= '0;
         cam_y_ff <= '0;
         cam_z_ff <= '0;
         ang_x_ff <= '0;
         ang_y_ff <= '0;
         ang_z_ff <= '0;
         gain_ff  <= 16'd256;
      end else if (csr_ch.valid) begin
         case (ppp_pkg::csr_reg_type'(csr_ch.index))
            ppp_pkg::REG_CAMERA_X:   cam_x_ff <= csr_ch.data;
            ppp_pkg::REG_CAMERA_Y:   cam_y_ff <= csr_ch.data;
            ppp_pkg::REG_CAMERA_Z:   cam_z_ff <= csr_ch.data;
            ppp_pkg::REG_ANGLE_X:    ang_x_ff <= csr_ch.data[8:0];
            ppp_pkg::REG_ANGLE_Y:    ang_y_ff <= csr_ch.data[8:0];
            ppp_pkg::REG_ANGLE_Z:    ang_z_ff <= csr_ch.data[8:0];
            ppp_pkg::REG_DEPTH_GAIN: gain_ff  <= csr_ch.data[15:0];
            default: ;
         endcase
      end
   end

   // Trig values are registered and follow the angle registers in the next cycle.
   always_comb begin
      trig_in.sin_x = ppp_pkg::sin_q15({1'b0, ang_x_ff});
      trig_in.cos_x = ppp_pkg::cos_q15(ang_x_ff);
      trig_in.sin_y = ppp_pkg::sin_q15({1'b0, ang_y_ff});
      trig_in.cos_y = ppp_pkg::cos_q15(ang_y_ff);
      trig_in.sin_z = ppp_pkg::sin_q15({1'b0, ang_z_ff});
      trig_in.cos_z = ppp_pkg::cos_q15(ang_z_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff.sin_x <= '0;
         trig_ff.cos_x <= 16'sd32767;
         trig_ff.sin_y <= '0;
         trig_ff.cos_y <= 16'sd32767;
         trig_ff.sin_z <= '0;
         trig_ff.cos_z <= 16'sd32767;
      end else begin
         trig_ff <= trig_in;
      end
   end

   assign trig_o = trig_ff;

   assign col30 = $signed({10'd0, req_ch.grid_col}) * 22'sd30;
   assign row30 = $signed({10'd0, req_ch.grid_row}) * 22'sd30;
   assign dx    = col30 - 22'(cam_x_ff);
   assign dy    = row30 - 22'(cam_y_ff);
   assign hz    = 34'(req_ch.height) * 34'($signed({1'b0, gain_ff}))
                - 34'($signed({cam_z_ff, 8'd0}));

   assign vtx_o.x = $signed({dx[21:0], 8'd0});
   assign vtx_o.y = $signed({dy[21:0], 8'd0});
   assign vtx_o.z = hz[ppp_pkg::Z_W-1:0];

   assign req_ch.ready = !full_i;
   assign push_o       = req_ch.valid && !full_i;

endmodule

FILE: rtl/core/ppp_queue.sv
// Short queue of placed vertices between the front end and the back end.
// Depends on ppp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "point_perspective_projector_assert.svh"
module ppp_queue #(
   parameter int unsigned DEPTH = ppp_pkg::QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic push_i,
   input  ppp_pkg::vertex_type data_i,
   input  logic pop_i,
   output ppp_pkg::vertex_type data_o,
   output logic full_o,
   output logic empty_o
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   ppp_pkg::vertex_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[wr_ptr_ff] <= data_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_i) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (pop_i) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         if (push_i && !pop_i) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop_i && !push_i) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign data_o  = mem_ff[rd_ptr_ff];
   assign full_o  = (count_ff == (PTR_W + 1)'(DEPTH));
   assign empty_o = (count_ff == '0);

   `PPP_ASSERT_IMP(a_no_push_full, full_o, !push_i)
   `PPP_ASSERT_IMP(a_no_pop_empty, empty_o, !pop_i)
   `PPP_ASSERT_NXT(a_count_up, push_i && !pop_i, count_ff == $past(count_ff) + 1'b1)

endmodule

FILE: rtl/core/ppp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module ppp_div #(
   parameter int unsigned NUM_W  = 46,
   parameter int unsigned DEN_W  = 34,
   parameter int unsigned SIDE_W = 1
) (
   input  logic clock,
   input  logic reset,
   input  logic en_i,
   input  logic valid_i,
   input  logic [NUM_W-1:0] num_i,
   input  logic [DEN_W-1:0] den_i,
   input  logic [SIDE_W-1:0] side_i,
   output logic valid_o,
   output logic [NUM_W-1:0] quo_o,
   output logic [SIDE_W-1:0] side_o
);

   // The numerator shifts out of nq while quotient bits shift in.
   logic [NUM_W-1:0]  nq_ff   [NUM_W];
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];
   logic              vld_ff  [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic [NUM_W-1:0]  nq_prev;
      logic [DEN_W-1:0]  rem_prev, den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              vld_prev;
      logic [DEN_W:0]    shifted;
      logic              ge;

      if (s == 0) begin : g_first
         assign nq_prev   = num_i;
         assign rem_prev  = '0;
         assign den_prev  = den_i;
         assign side_prev = side_i;
         assign vld_prev  = valid_i;
      end else begin : g_next
         assign nq_prev   = nq_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
         assign den_prev  = den_ff[s-1];
         assign side_prev = side_ff[s-1];
         assign vld_prev  = vld_ff[s-1];
      end

      assign shifted = {rem_prev, nq_prev[NUM_W-1]};
      assign ge      = (shifted >= {1'b0, den_prev});

      always_ff @(posedge clock) begin
         if (en_i) begin
            rem_ff[s]  <= ge ? DEN_W'(shifted - {1'b0, den_prev}) : shifted[DEN_W-1:0];
            nq_ff[s]   <= {nq_prev[NUM_W-2:0], ge};
            den_ff[s]  <= den_prev;
            side_ff[s] <= side_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en_i) begin
            vld_ff[s] <= vld_prev;
         end
      end
   end

   assign valid_o = vld_ff[NUM_W-1];
   assign quo_o   = nq_ff[NUM_W-1];
   assign side_o  = side_ff[NUM_W-1];

endmodule

FILE: rtl/core/ppp_back.sv
// Back end: three rotation steps, two dividers and the output register.
// Depends on ppp_pkg and ppp_div.
`timescale 1ns / 1ps
module ppp_back #(
   parameter int unsigned SCREEN_WIDTH  = ppp_pkg::DEF_SCREEN_WIDTH,
   parameter int unsigned SCREEN_HEIGHT = ppp_pkg::DEF_SCREEN_HEIGHT
) (
   input  logic clock,
   input  logic reset,
   input  logic empty_i,
   input  ppp_pkg::vertex_type vtx_i,
   input  ppp_pkg::trig_type trig_i,
   output logic pop_o,
   input  logic rsp_ready_i,
   output logic rsp_valid_o,
   output logic signed [31:0] screen_x_o,
   output logic signed [31:0] screen_y_o,
   output logic [1:0] status_o
);

   localparam int unsigned ROT_W  = ppp_pkg::ROT_W;
   localparam int unsigned PROD_W = ppp_pkg::PROD_W;
   localparam int unsigned SUM_W  = ppp_pkg::SUM_W;
   localparam int unsigned NUM_W  = ppp_pkg::NUM_W;
   localparam int unsigned DEN_W  = ppp_pkg::DEN_W;
   localparam int unsigned SCR_W  = ppp_pkg::SCR_W;
   localparam logic signed [SCR_W-1:0] OFF_X = SCR_W'((SCREEN_WIDTH / 2) * 256);
   localparam logic signed [SCR_W-1:0] OFF_Y = SCR_W'((SCREEN_HEIGHT / 2) * 256);
   localparam logic signed [SCR_W-1:0] S32_MAX = SCR_W'(64'sd2147483647);
   localparam logic signed [SCR_W-1:0] S32_MIN = -SCR_W'(64'sd2147483648);

   logic en;
   logic [6:0] vld_ff;
   logic rsp_valid_ff;

   logic signed [PROD_W-1:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [PROD_W-1:0] p5_ff, p6_ff, p7_ff, p8_ff;
   logic signed [PROD_W-1:0] p9_ff, p10_ff, p11_ff, p12_ff;
   logic signed [ROT_W-1:0]  z1_ff, z2_ff, a_ff, b2_ff, b3_ff, b4_ff;
   logic signed [ROT_W-1:0]  c_ff, xr4_ff, xr5_ff, xr6_ff, yr_ff, zr_ff;
   logic signed [ROT_W-1:0]  x_in, y_in, z_in;

   logic signed [NUM_W+1:0] nx, ny;
   logic [NUM_W-1:0] nx_mag_ff, ny_mag_ff;
   logic [DEN_W-1:0] den_mag_ff;
   logic sx_ff, sy_ff, zero_ff;

   logic dx_valid, dy_valid;
   logic [NUM_W-1:0] qx, qy;
   logic [1:0] side_x;
   logic [0:0] side_y;
   logic signed [SCR_W-1:0] px, py;
   logic sat_x, sat_y;
   logic signed [31:0] screen_x_in, screen_y_in;
   logic [1:0] status_in;
   logic signed [31:0] screen_x_ff, screen_y_ff;
   logic [1:0] status_ff;

   // The whole back end moves together whenever the output can take a result.
   assign en    = !rsp_valid_ff || rsp_ready_i;
   assign pop_o = en && !empty_i;

   assign x_in = ROT_W'(vtx_i.x);
   assign y_in = ROT_W'(vtx_i.y);
   assign z_in = ROT_W'(vtx_i.z);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[5:0], pop_o};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // Rotation about z.
         p1_ff  <= trig_i.sin_z * y_in;
         p2_ff  <= trig_i.cos_z * x_in;
         p3_ff  <= trig_i.cos_z * y_in;
         p4_ff  <= trig_i.sin_z * x_in;
         z1_ff  <= z_in;
         a_ff   <= ppp_pkg::round15(SUM_W'(p1_ff) + SUM_W'(p2_ff));
         b2_ff  <= ppp_pkg::round15(SUM_W'(p3_ff) - SUM_W'(p4_ff));
         z2_ff  <= z1_ff;
         // Rotation about y.
         p5_ff  <= trig_i.cos_y * z2_ff;
         p6_ff  <= trig_i.sin_y * a_ff;
         p7_ff  <= trig_i.cos_y * a_ff;
         p8_ff  <= trig_i.sin_y * z2_ff;
         b3_ff  <= b2_ff;
         c_ff   <= ppp_pkg::round15(SUM_W'(p5_ff) + SUM_W'(p6_ff));
         xr4_ff <= ppp_pkg::round15(SUM_W'(p7_ff) - SUM_W'(p8_ff));
         b4_ff  <= b3_ff;
         // Rotation about x.
         p9_ff  <= trig_i.sin_x * c_ff;
         p10_ff <= trig_i.cos_x * b4_ff;
         p11_ff <= trig_i.cos_x * c_ff;
         p12_ff <= trig_i.sin_x * b4_ff;
         xr5_ff <= xr4_ff;
         yr_ff  <= ppp_pkg::round15(SUM_W'(p9_ff) + SUM_W'(p10_ff));
         zr_ff  <= ppp_pkg::round15(SUM_W'(p11_ff) - SUM_W'(p12_ff));
         xr6_ff <= xr5_ff;
      end
   end

   // Numerators are -2560 times the rotated x and y; signs go around the dividers.
   assign nx = -(NUM_W + 2)'(xr6_ff) * (NUM_W + 2)'(2560);
   assign ny = -(NUM_W + 2)'(yr_ff) * (NUM_W + 2)'(2560);

   always_ff @(posedge clock) begin
      if (en) begin
         nx_mag_ff  <= nx[NUM_W+1] ? NUM_W'(-nx) : NUM_W'(nx);
         ny_mag_ff  <= ny[NUM_W+1] ? NUM_W'(-ny) : NUM_W'(ny);
         den_mag_ff <= zr_ff[ROT_W-1] ? DEN_W'(-zr_ff) : DEN_W'(zr_ff);
         sx_ff      <= nx[NUM_W+1] ^ zr_ff[ROT_W-1];
         sy_ff      <= ny[NUM_W+1] ^ zr_ff[ROT_W-1];
         zero_ff    <= (zr_ff == '0);
      end
   end

   ppp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(2)) u_div_x (
      .clock   (clock),
      .reset   (reset),
      .en_i    (en),
      .valid_i (vld_ff[6]),
      .num_i   (nx_mag_ff),
      .den_i   (den_mag_ff),
      .side_i  ({zero_ff, sx_ff}),
      .valid_o (dx_valid),
      .quo_o   (qx),
      .side_o  (side_x)
   );

   ppp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(1)) u_div_y (
      .clock   (clock),
      .reset   (reset),
      .en_i    (en),
      .valid_i (vld_ff[6]),
      .num_i   (ny_mag_ff),
      .den_i   (den_mag_ff),
      .side_i  (sy_ff),
      .valid_o (dy_valid),
      .quo_o   (qy),
      .side_o  (side_y)
   );

   always_comb begin
      px = (side_x[0] ? -SCR_W'(qx) : SCR_W'(qx)) + OFF_X;
      py = (side_y[0] ? -SCR_W'(qy) : SCR_W'(qy)) - OFF_Y;
      sat_x = 1'b0;
      sat_y = 1'b0;
      screen_x_in = px[31:0];
      screen_y_in = py[31:0];
      if (px > S32_MAX) begin
         screen_x_in = 32'sh7FFFFFFF;
         sat_x = 1'b1;
      end else if (px < S32_MIN) begin
         screen_x_in = 32'sh80000000;
         sat_x = 1'b1;
      end
      if (py > S32_MAX) begin
         screen_y_in = 32'sh7FFFFFFF;
         sat_y = 1'b1;
      end else if (py < S32_MIN) begin
         screen_y_in = 32'sh80000000;
         sat_y = 1'b1;
      end
      status_in = ppp_pkg::ST_OK;
      if (side_x[1]) begin
         screen_x_in = '0;
         screen_y_in = '0;
         status_in   = ppp_pkg::ST_ZERO_DEPTH;
      end else if (sat_x || sat_y) begin
         status_in = ppp_pkg::ST_SATURATED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dx_valid && dy_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         screen_x_ff <= screen_x_in;
         screen_y_ff <= screen_y_in;
         status_ff   <= status_in;
      end
   end

   assign rsp_valid_o = rsp_valid_ff;
   assign screen_x_o  = screen_x_ff;
   assign screen_y_o  = screen_y_ff;
   assign status_o    = status_ff;

endmodule

FILE: rtl/core/point_perspective_projector.sv
// Top level of the vertex perspective projector.
// Depends on ppp_pkg, ppp_if, ppp_front, ppp_queue, ppp_back and ppp_div.
//
//   channel  | direction | carries
//   ---------+-----------+----------------------------------------------
//   req_ch   | in        | one vertex item: grid_col, grid_row, height
//   rsp_ch   | out       | one screen item: screen_x, screen_y, status
//   csr_ch   | in        | register write: index, data (always ready)
//
// One item is accepted per cycle and one result leaves per cycle when the
// output is not stalled. An accepted item lands in the queue at the accepting
// edge, then passes six rotation stages, the sign and magnitude register, a
// 46-stage divider (one quotient bit per stage) and the output register. Reset
// is synchronous and clears the control state and the configuration registers,
// not the pipeline data; afterwards the block takes items at once. A stalled
// output freezes the back end in place; the front keeps filling the four-entry
// queue until it is full.
`timescale 1ns / 1ps
module point_perspective_projector #(
   parameter int unsigned SCREEN_WIDTH  = ppp_pkg::DEF_SCREEN_WIDTH,
   parameter int unsigned SCREEN_HEIGHT = ppp_pkg::DEF_SCREEN_HEIGHT
) (
   input logic clock,
   input logic reset,
   ppp_req_if.sink   req_ch,
   ppp_rsp_if.source rsp_ch,
   ppp_csr_if.sink   csr_ch
);

   logic push, pop, full, empty;
   ppp_pkg::vertex_type vtx_front, vtx_queue;
   ppp_pkg::trig_type trig;

   // The front places each vertex in world space as it is accepted.
   ppp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .req_ch (req_ch),
      .full_i (full),
      .push_o (push),
      .vtx_o  (vtx_front),
      .trig_o (trig)
   );

   // The queue lets the front keep taking items while the back is stalled.
   ppp_queue #(.DEPTH(ppp_pkg::QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .data_i  (vtx_front),
      .pop_i   (pop),
      .data_o  (vtx_queue),
      .full_o  (full),
      .empty_o (empty)
   );

   // The back rotates, divides and registers the result.
   ppp_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .empty_i     (empty),
      .vtx_i       (vtx_queue),
      .trig_i      (trig),
      .pop_o       (pop),
      .rsp_ready_i (rsp_ch.ready),
      .rsp_valid_o (rsp_ch.valid),
      .screen_x_o  (rsp_ch.screen_x),
      .screen_y_o  (rsp_ch.screen_y),
      .status_o    (rsp_ch.status)
   );

endmodule

FILE: test/tb_point_perspective_projector.sv
// Self-checking testbench of the vertex perspective projector: directed and random vertices
// under several camera settings, checked against an in-bench projection predictor.
// Depends on ppp_pkg, ppp_if and the point_perspective_projector RTL.
`timescale 1ns / 1ps
module tb_point_perspective_projector;

   localparam int unsigned HALF_W = 1024 / 2;
   localparam int unsigned HALF_H = 768 / 2;
   localparam int          PIPE_LATENCY = 55;
   localparam longint      CYCLE_LIMIT = 400000;
   localparam logic [ppp_pkg::CSR_IDX_W-1:0] UNUSED_REG_INDEX = 3'd7;

   typedef struct packed {
      logic [11:0]        grid_col;
      logic [11:0]        grid_row;
      logic signed [15:0] height;
   } vertex_item_type;

   typedef struct packed {
      logic signed [31:0]  screen_x;
      logic signed [31:0]  screen_y;
      ppp_pkg::status_type status;
   } screen_item_type;

   logic clock;
   logic reset;

   ppp_req_if req_ch ();
   ppp_rsp_if rsp_ch ();
   ppp_csr_if csr_ch ();

   point_perspective_projector dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // Mirror of the camera registers, updated on each accepted register write.
   logic signed [20:0] cam_x, cam_y, cam_z;
   logic [8:0]         ang_x, ang_y, ang_z;
   logic [15:0]        gain;

   vertex_item_type pending_vertices[$];
   screen_item_type expected_screens[$];
   int              error_count;
   longint          cycle_count;
   bit              stall_free;       // set near the end to turn off random idling
   int              hold_off_cycles;  // long receiver stall requested by the stimulus
   int              send_gap;
   int              recv_gap;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sine in Q1.15 for any 9-bit angle; values 360 and above wrap once.
   function automatic longint sine_of(input int unsigned deg);
      int unsigned d;
      d = (deg >= 360) ? deg - 360 : deg;
      if (d <= 90) return longint'(ppp_pkg::SIN_QUARTER[d]);
      if (d <= 180) return longint'(ppp_pkg::SIN_QUARTER[180 - d]);
      if (d <= 270) return -longint'(ppp_pkg::SIN_QUARTER[d - 180]);
      return -longint'(ppp_pkg::SIN_QUARTER[360 - d]);
   endfunction

   function automatic longint cosine_of(input int unsigned deg);
      int unsigned d;
      d = (deg >= 360) ? deg - 360 : deg;
      return sine_of(d + 90);
   endfunction

   // Drops 15 fraction bits with halves rounded away from zero.
   function automatic longint round_q15(input longint p);
      if (p < 0) return -((-p + 16384) >>> 15);
      return (p + 16384) >>> 15;
   endfunction

   function automatic longint clamp_screen(input longint v, inout bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Places, rotates and projects one vertex with the current camera settings.
   function automatic screen_item_type project_vertex(input vertex_item_type v);
      screen_item_type r;
      longint x, y, z, sx, cx, sy, cy, sz, cz, a, b, c, xr, yr, zr, px, py;
      bit sat;
      x = (longint'(v.grid_col) * 30 - longint'(cam_x)) * 256;
      y = (longint'(v.grid_row) * 30 - longint'(cam_y)) * 256;
      z = longint'(v.height) * longint'(gain) - longint'(cam_z) * 256;
      sx = sine_of(ang_x); cx = cosine_of(ang_x);
      sy = sine_of(ang_y); cy = cosine_of(ang_y);
      sz = sine_of(ang_z); cz = cosine_of(ang_z);
      a  = round_q15(sz * y + cz * x);
      b  = round_q15(cz * y - sz * x);
      c  = round_q15(cy * z + sy * a);
      xr = round_q15(cy * a - sy * z);
      yr = round_q15(sx * c + cx * b);
      zr = round_q15(cx * c - sx * b);
      sat = 1'b0;
      r.status = ppp_pkg::ST_OK;
      r.screen_x = '0;
      r.screen_y = '0;
      if (zr == 0) begin
         r.status = ppp_pkg::ST_ZERO_DEPTH;
      end else begin
         // SystemVerilog division of signed integers truncates toward zero.
         px = (-2560 * xr) / zr + longint'(HALF_W) * 256;
         py = (-2560 * yr) / zr - longint'(HALF_H) * 256;
         px = clamp_screen(px, sat);
         py = clamp_screen(py, sat);
         r.screen_x = px[31:0];
         r.screen_y = py[31:0];
         if (sat) r.status = ppp_pkg::ST_SATURATED;
      end
      return r;
   endfunction

   // Input driver: offers queued vertices with random idle bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_screens.push_back(project_vertex({req_ch.grid_col, req_ch.grid_row,
                                                       req_ch.height}));
            void'(pending_vertices.pop_front());
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_ch.valid <= 1'b0;
            end else if ((req_ch.valid && req_ch.ready ? pending_vertices.size() > 1
                                                       : pending_vertices.size() > 0)) begin
               vertex_item_type nxt;
               nxt = (req_ch.valid && req_ch.ready) ? pending_vertices[1] : pending_vertices[0];
               req_ch.valid    <= 1'b1;
               req_ch.grid_col <= nxt.grid_col;
               req_ch.grid_row <= nxt.grid_row;
               req_ch.height   <= nxt.height;
               if (!stall_free && $urandom_range(7) == 0) send_gap <= $urandom_range(1, 4);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Counts down the long receiver stall requested by the stimulus.
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
      end
   end

   // Result monitor: compares every accepted item with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_screens.size() == 0) begin
               $error("unexpected result item: screen_x %0d screen_y %0d status %0d",
                      rsp_ch.screen_x, rsp_ch.screen_y, rsp_ch.status);
               error_count = error_count + 1;
            end else begin
               screen_item_type e;
               e = expected_screens.pop_front();
               if (rsp_ch.screen_x !== e.screen_x) begin
                  $error("screen_x expected %0d actual %0d", e.screen_x, rsp_ch.screen_x);
                  error_count = error_count + 1;
               end
               if (rsp_ch.screen_y !== e.screen_y) begin
                  $error("screen_y expected %0d actual %0d", e.screen_y, rsp_ch.screen_y);
                  error_count = error_count + 1;
               end
               if (rsp_ch.status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_ch.status);
                  error_count = error_count + 1;
               end
            end
         end
         // The long hold-off lets the internal queue fill and push back on the input.
         if (hold_off_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!stall_free && $urandom_range(7) == 0) recv_gap <= $urandom_range(1, 4);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("point_perspective_projector regression: fail");
         $finish;
      end
   end

   // Writes one register through the csr channel and mirrors it locally.
   task automatic write_reg(input ppp_pkg::csr_reg_type idx, input logic [20:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         ppp_pkg::REG_CAMERA_X:   cam_x = value;
         ppp_pkg::REG_CAMERA_Y:   cam_y = value;
         ppp_pkg::REG_CAMERA_Z:   cam_z = value;
         ppp_pkg::REG_ANGLE_X:    ang_x = value[8:0];
         ppp_pkg::REG_ANGLE_Y:    ang_y = value[8:0];
         ppp_pkg::REG_ANGLE_Z:    ang_z = value[8:0];
         ppp_pkg::REG_DEPTH_GAIN: gain  = value[15:0];
         default: ;
      endcase
   endtask

   task automatic set_camera(input logic [20:0] px, input logic [20:0] py,
                             input logic [20:0] pz, input logic [8:0] ax,
                             input logic [8:0] ay, input logic [8:0] az,
                             input logic [15:0] g);
      write_reg(ppp_pkg::REG_CAMERA_X, px);
      write_reg(ppp_pkg::REG_CAMERA_Y, py);
      write_reg(ppp_pkg::REG_CAMERA_Z, pz);
      write_reg(ppp_pkg::REG_ANGLE_X, {12'd0, ax});
      write_reg(ppp_pkg::REG_ANGLE_Y, {12'd0, ay});
      write_reg(ppp_pkg::REG_ANGLE_Z, {12'd0, az});
      write_reg(ppp_pkg::REG_DEPTH_GAIN, {5'd0, g});
   endtask

   // Waits for the block to drain so the registers can be changed safely.
   task automatic wait_drained();
      while (pending_vertices.size() != 0 || req_ch.valid || expected_screens.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_vertex(input logic [11:0] col, input logic [11:0] row,
                             input logic [15:0] h);
      vertex_item_type v;
      v.grid_col = col;
      v.grid_row = row;
      v.height   = h;
      pending_vertices.push_back(v);
   endtask

   // Mostly small grid values near the camera, with full-range outliers.
   task automatic add_random_vertices(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0)
            add_vertex(12'($urandom), 12'($urandom), 16'($urandom));
         else
            add_vertex(12'($urandom_range(63)), 12'($urandom_range(63)),
                       16'($urandom_range(600) - 300));
      end
   endtask

   task automatic random_camera();
      set_camera(21'($urandom_range(3) == 0 ? $urandom : $urandom_range(4000) - 2000),
                 21'($urandom_range(3) == 0 ? $urandom : $urandom_range(4000) - 2000),
                 21'($urandom_range(3) == 0 ? $urandom : $urandom_range(4000) - 2000),
                 9'($urandom), 9'($urandom), 9'($urandom), 16'($urandom));
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.grid_col = '0;
      req_ch.grid_row = '0;
      req_ch.height = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = ppp_pkg::REG_CAMERA_X;
      csr_ch.data = '0;
      error_count = 0;
      cycle_count = 0;
      stall_free = 1'b0;
      hold_off_cycles = 0;
      cam_x = '0; cam_y = '0; cam_z = '0;
      ang_x = '0; ang_y = '0; ang_z = '0;
      gain = 16'd256;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed items at reset values: the origin vertex has zero depth.
      add_vertex(12'd0, 12'd0, 16'sd0);
      add_vertex(12'd4095, 12'd4095, 16'sd32767);
      add_vertex(12'd0, 12'd4095, -16'sd32768);
      add_vertex(12'd1, 12'd0, 16'sd1);
      add_vertex(12'd4095, 12'd0, -16'sd1);
      add_vertex(12'd2730, 12'd1365, 16'sh5555);
      add_vertex(12'd1365, 12'd2730, 16'shAAAA);
      wait_drained();

      // Camera at z of one with zero gain: tiny depth and large ratios drive saturation.
      set_camera(21'h0FFFFF, 21'h100000, 21'h000001, 9'd0, 9'd0, 9'd0, 16'd0);
      add_vertex(12'd0, 12'd0, 16'sd0);
      add_vertex(12'd4095, 12'd4095, 16'sd5);
      add_vertex(12'd0, 12'd4095, -16'sd32768);
      wait_drained();
      // Out-of-range angles that wrap, maximum gain, opposite camera extremes.
      set_camera(21'h100000, 21'h0FFFFF, 21'h100000, 9'd511, 9'd450, 9'd360,
                 16'hFFFF);
      add_vertex(12'd0, 12'd0, 16'sd0);
      add_vertex(12'd4095, 12'd4095, 16'sd32767);
      add_vertex(12'd17, 12'd3, -16'sd32768);
      wait_drained();
      set_camera(21'd0, 21'd0, 21'd0, 9'd90, 9'd180, 9'd270, 16'd256);
      add_vertex(12'd0, 12'd0, 16'sd1);
      add_vertex(12'd5, 12'd9, -16'sd7);
      add_vertex(12'd4095, 12'd1, 16'sd100);
      wait_drained();
      // An index above the last register must leave every setting alone.
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= UNUSED_REG_INDEX;
      csr_ch.data  <= 21'h1FFFFF;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      add_vertex(12'd3, 12'd4, 16'sd5);
      wait_drained();

      // Random phases with a fresh camera each time.
      for (int phase = 0; phase < 8; phase++) begin
         random_camera();
         add_random_vertices(200);
         if (phase == 2) hold_off_cycles = 300;
         wait_drained();
      end
      stall_free = 1'b1;
      add_random_vertices(250);
      wait_drained();
      repeat (PIPE_LATENCY + 10) @(posedge clock);

      if (error_count == 0 && expected_screens.size() == 0) begin
         $display("point_perspective_projector regression: pass");
      end else begin
         $display("point_perspective_projector regression: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/ppp_pkg.sv
rtl/core/ppp_if.sv
rtl/core/ppp_front.sv
rtl/core/ppp_queue.sv
rtl/core/ppp_div.sv
rtl/core/ppp_back.sv
rtl/core/point_perspective_projector.sv
test/tb_point_perspective_projector.sv
